>>> hdl/from_to_rotation_matrix_macros.svh
// Assertion macros for the rotation matrix block
`ifndef FROM_TO_ROTATION_MATRIX_MACROS_SVH
`define FROM_TO_ROTATION_MATRIX_MACROS_SVH
// a implies b in the next cycle
`define FTRM_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("check failed");
// a implies b in the same cycle
`define FTRM_SAME(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("check failed");
`endif

>>> hdl/ftrm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftrm_pkg
// Shared codes and constants of the rotation matrix block.
// ----------------------------------------------------------------------------
package ftrm_pkg;
    localparam logic [1:0] CASE_GENERAL = 2'd0;
    localparam logic [1:0] CASE_IDENT   = 2'd1;
    localparam logic [1:0] CASE_ANTI    = 2'd2;
    localparam int CFG_W = 13;
    localparam logic [CFG_W-1:0] THRESH_RESET = 13'd1;
endpackage

>>> hdl/from_to_rotation_matrix.sv
`timescale 1ns / 1ps
// Pipeline from input transfer to result on the ports: two front stages, DATA_WIDTH+1
// square root and 2*DATA_WIDTH+2 divider stages, three back end stages and the queue
// write. Throughput: one transfer per cycle while the queue is not full; divider and
// square root are fully pipelined. The output queue holds results; the whole pipeline
// stalls while the queue is full.
// Reset: asynchronous active low; pipeline and queue empty, threshold is 1.
// ----------------------------------------------------------------------------
// from_to_rotation_matrix
// Rotation matrix taking one unit vector onto another.
// ----------------------------------------------------------------------------
module from_to_rotation_matrix #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS = 14
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  logic signed [DATA_WIDTH-1:0] from_x, from_y, from_z, to_x, to_y, to_z,
    output logic empty,
    input  logic pop,
    output logic signed [DATA_WIDTH-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22,
    output logic [1:0] case_code,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [12:0] cfg_data
);
    import ftrm_pkg::*;
    localparam int OW = 9*DATA_WIDTH+2;
    logic [12:0] thr_reg;
    logic cvld, qfull, qempty, en;
    logic [OW-1:0] cdata, qdata;
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) thr_reg <= THRESH_RESET;
        else if (cfg_valid) thr_reg <= cfg_data;
    end
    // the pipeline only advances when the queue can take its output
    assign en = !qfull;
    assign full = qfull;
    ftrm_core #(.DW(DATA_WIDTH), .FB(FRAC_BITS)) u_core (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(push), .thr(thr_reg),
        .fx(from_x), .fy(from_y), .fz(from_z), .tx(to_x), .ty(to_y), .tz(to_z),
        .out_vld(cvld), .out_data(cdata));
    ftrm_fifo #(.W(OW), .DEPTH_LOG(2)) u_q (
        .clk(clk), .rst_n(rst_n), .wr(cvld && en), .wdata(cdata), .rd(pop),
        .rdata(qdata), .empty(qempty), .full(qfull));
    assign empty = qempty;
    assign {m00, m01, m02, m10, m11, m12, m20, m21, m22, case_code} = qdata;
endmodule

>>> hdl/ftrm_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftrm_fifo
// Small first-in first-out queue with registered storage.
// ----------------------------------------------------------------------------
module ftrm_fifo #(
    parameter int W = 8,
    parameter int DEPTH_LOG = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr,
    input  logic [W-1:0] wdata,
    input  logic         rd,
    output logic [W-1:0] rdata,
    output logic         empty,
    output logic         full
);
    localparam int DEPTH = 1 << DEPTH_LOG;
    logic [W-1:0] mem [DEPTH];
    logic [DEPTH_LOG-1:0] wp_reg, rp_reg;
    logic [DEPTH_LOG:0] cnt_reg;
    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == (DEPTH_LOG+1)'(DEPTH));
    assign rdata = mem[rp_reg];
    always_ff @(posedge clk)
    begin
        if (wr && !full)
        begin
            mem[wp_reg] <= wdata;
        end
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr && !full) wp_reg <= wp_reg + 1'b1;
            if (rd && !empty) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (DEPTH_LOG+1)'(wr && !full) - (DEPTH_LOG+1)'(rd && !empty);
        end
    end
endmodule

>>> hdl/ftrm_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftrm_core
// Pipelined arithmetic: classification front and matrix back end.
// ----------------------------------------------------------------------------
module ftrm_core #(
    parameter int DW = 16,
    parameter int FB = 14
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_vld,
    input  logic [12:0]        thr,
    input  logic signed [DW-1:0] fx, fy, fz, tx, ty, tz,
    output logic               out_vld,
    output logic [9*DW+1:0]    out_data
);
    import ftrm_pkg::*;
    localparam int PW = 2*DW+2;
    // stage map: 0 cross/dot, 1 classify, then isqrt two bits per stage,
    // then restoring divider one bit per stage
    localparam int SQ0 = 2;
    localparam int SQN = PW/2;
    localparam int DV0 = SQ0 + SQN;
    localparam int DVN = PW;
    localparam int LAST = DV0 + DVN;
    localparam int NS = LAST - 1;
    typedef logic signed [PW-1:0] w_t;
    localparam w_t DMAX = w_t'((64'sd1 <<< (DW-1)) - 1);
    localparam w_t DMIN = -w_t'(64'sd1 <<< (DW-1));
    localparam w_t ONEW = w_t'(64'sd1 <<< FB);

    function automatic logic signed [DW-1:0] sat(input w_t x);
        if (x > DMAX) return DW'(DMAX);
        if (x < DMIN) return DW'(DMIN);
        return DW'(x);
    endfunction
    function automatic w_t mq(input logic signed [DW-1:0] a, input logic signed [DW-1:0] b);
        logic signed [2*DW-1:0] p;
        p = a * b;
        return w_t'(p >>> FB);
    endfunction

    // stage arrays: one stage per pipeline step, all advance with en
    typedef struct packed {
        logic vld;
        logic [1:0] code;
        logic [12:0] thr;
        logic signed [DW-1:0] fx, fy, fz, tx, ty, tz, e, vx, vy, vz, lx, ly, lz;
        logic [PW-1:0] num;
        logic [PW-1:0] den;
        logic [PW-1:0] q;
        logic [PW-1:0] rem;
        logic [PW-1:0] sqr;
        logic [PW-1:0] sqx;
    } st_t;
    st_t s [NS+1];

    // stage 0 combinational: cross and dot
    st_t a0;
    always_comb
    begin
        a0 = '0;
        a0.vld = in_vld;
        a0.thr = thr;
        a0.fx = fx; a0.fy = fy; a0.fz = fz;
        a0.tx = tx; a0.ty = ty; a0.tz = tz;
        a0.vx = sat(mq(fy, tz) - mq(fz, ty));
        a0.vy = sat(mq(fz, tx) - mq(fx, tz));
        a0.vz = sat(mq(fx, ty) - mq(fy, tx));
        a0.e = sat(mq(fx, tx) + mq(fy, ty) + mq(fz, tz));
    end
    // stage 1: classify, pick left, set up divide/sqrt operands
    st_t a1;
    always_comb
    begin
        w_t eps, e, l2a, l2b, l2;
        logic signed [DW-1:0] nz, ax;
        a1 = s[0];
        eps = w_t'(s[0].thr);
        e = w_t'(s[0].e);
        if (e > ONEW - eps) a1.code = CASE_IDENT;
        else if (e < eps - ONEW) a1.code = CASE_ANTI;
        else a1.code = CASE_GENERAL;
        // both left candidates are sized side by side
        nz = sat(-w_t'(s[0].fy));
        ax = sat(-w_t'(s[0].fz));
        l2a = w_t'(sat(mq(s[0].fz, s[0].fz) + mq(nz, nz)));
        l2b = w_t'(sat(mq(ax, ax) + mq(s[0].fx, s[0].fx)));
        a1.lx = '0; a1.ly = s[0].fz; a1.lz = nz;
        l2 = l2a;
        if (l2a < eps)
        begin
            a1.lx = ax; a1.ly = '0; a1.lz = s[0].fx;
            l2 = l2b;
        end
        if (a1.code == CASE_ANTI)
        begin
            a1.sqx = (l2 > 0) ? PW'(l2 <<< FB) : '0;
            a1.num = PW'(ONEW * ONEW);
        end
        else
        begin
            a1.sqx = '0;
            a1.num = PW'((ONEW - e) * ONEW);
        end
        a1.den = PW'(w_t'(sat(mq(s[0].vx, s[0].vx) + mq(s[0].vy, s[0].vy)
                               + mq(s[0].vz, s[0].vz))));
        a1.sqr = '0; a1.q = '0; a1.rem = '0;
    end
    st_t nx [NS+1];
    always_comb
    begin
        for (int k = 0; k <= NS; k++) nx[k] = s[k];
        for (int k = SQ0; k < SQ0 + SQN; k++)
        begin
            logic [PW-1:0] bitv, t;
            bitv = PW'(1) << (2*(SQN-1-(k-SQ0)));
            nx[k] = s[k-1];
            t = nx[k].sqr + bitv;
            if (nx[k].sqx >= t)
            begin
                nx[k].sqx = nx[k].sqx - t;
                nx[k].sqr = (nx[k].sqr >> 1) + bitv;
            end
            else nx[k].sqr = nx[k].sqr >> 1;
        end
        for (int k = DV0; k < DV0 + DVN; k++)
        begin
            logic [PW:0] r;
            logic [PW-1:0] d;
            int b;
            b = DVN-1-(k-DV0);
            nx[k] = s[k-1];
            if (k == DV0)
            begin
                if (nx[k].code == CASE_ANTI) nx[k].den = nx[k].sqr;
                nx[k].rem = '0;
                nx[k].q = '0;
            end
            d = nx[k].den;
            r = {nx[k].rem, nx[k].num[b]};
            if (d != '0 && r >= {1'b0, d})
            begin
                nx[k].rem = PW'(r - {1'b0, d});
                nx[k].q[b] = 1'b1;
            end
            else nx[k].rem = PW'(r);
        end
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= NS; k++) s[k].vld <= 1'b0;
        end
        else if (en)
        begin
            s[0] <= a0;
            s[1] <= a1;
            for (int k = SQ0; k < LAST; k++) s[k] <= nx[k];
        end
    end

    // back end, three steps: scale, second products, matrix assembly
    typedef struct packed {
        logic vld;
        logic [1:0] code;
        logic signed [DW-1:0] e, vx, vy, vz, fx, fy, fz, p0, p1, p2, q0, q1, q2;
    } bk_t;
    bk_t b1_reg, b1_next, b2_reg, b2_next;

    // scaled left (anti-parallel) or h*v (general)
    always_comb
    begin
        st_t z;
        logic signed [DW-1:0] qs;
        z = s[LAST-1];
        qs = (z.den == '0) ? '0 : sat(w_t'(z.q));
        b1_next = '0;
        b1_next.vld = z.vld;
        b1_next.code = z.code;
        b1_next.e = z.e;
        b1_next.vx = z.vx; b1_next.vy = z.vy; b1_next.vz = z.vz;
        b1_next.fx = z.fx; b1_next.fy = z.fy; b1_next.fz = z.fz;
        if (z.code == CASE_ANTI)
        begin
            b1_next.p0 = sat(mq(z.lx, qs));
            b1_next.p1 = sat(mq(z.ly, qs));
            b1_next.p2 = sat(mq(z.lz, qs));
        end
        else
        begin
            b1_next.p0 = sat(mq(qs, z.vx));
            b1_next.p1 = sat(mq(qs, z.vy));
            b1_next.p2 = sat(mq(qs, z.vz));
        end
    end
    // up = left x from, or the h*v cross terms
    always_comb
    begin
        b2_next = b1_reg;
        if (b1_reg.code == CASE_ANTI)
        begin
            b2_next.q0 = sat(mq(b1_reg.p1, b1_reg.fz) - mq(b1_reg.p2, b1_reg.fy));
            b2_next.q1 = sat(mq(b1_reg.p2, b1_reg.fx) - mq(b1_reg.p0, b1_reg.fz));
            b2_next.q2 = sat(mq(b1_reg.p0, b1_reg.fy) - mq(b1_reg.p1, b1_reg.fx));
        end
        else
        begin
            b2_next.q0 = sat(mq(b1_reg.p0, b1_reg.vy));
            b2_next.q1 = sat(mq(b1_reg.p0, b1_reg.vz));
            b2_next.q2 = sat(mq(b1_reg.p2, b1_reg.vy));
        end
    end
    logic signed [DW-1:0] m [9];
    always_comb
    begin
        logic signed [DW-1:0] lv [3], uv [3], fv [3];
        lv[0] = b2_reg.p0; lv[1] = b2_reg.p1; lv[2] = b2_reg.p2;
        uv[0] = b2_reg.q0; uv[1] = b2_reg.q1; uv[2] = b2_reg.q2;
        fv[0] = b2_reg.fx; fv[1] = b2_reg.fy; fv[2] = b2_reg.fz;
        for (int i = 0; i < 9; i++) m[i] = '0;
        if (b2_reg.code == CASE_IDENT)
        begin
            m[0] = sat(ONEW); m[4] = sat(ONEW); m[8] = sat(ONEW);
        end
        else if (b2_reg.code == CASE_ANTI)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    m[i*3+j] = sat(-mq(fv[i], fv[j]) + mq(uv[i], uv[j]) - mq(lv[i], lv[j]));
        end
        else
        begin
            m[0] = sat(w_t'(b2_reg.e) + mq(b2_reg.p0, b2_reg.vx));
            m[1] = sat(w_t'(b2_reg.q0) - w_t'(b2_reg.vz));
            m[2] = sat(w_t'(b2_reg.q1) + w_t'(b2_reg.vy));
            m[3] = sat(w_t'(b2_reg.q0) + w_t'(b2_reg.vz));
            m[4] = sat(w_t'(b2_reg.e) + mq(b2_reg.p1, b2_reg.vy));
            m[5] = sat(w_t'(b2_reg.q2) - w_t'(b2_reg.vx));
            m[6] = sat(w_t'(b2_reg.q1) - w_t'(b2_reg.vy));
            m[7] = sat(w_t'(b2_reg.q2) + w_t'(b2_reg.vx));
            m[8] = sat(w_t'(b2_reg.e) + mq(b2_reg.p2, b2_reg.vz));
        end
    end
    logic vld_reg;
    logic [9*DW+1:0] data_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_reg <= '0;
            b2_reg <= '0;
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            b1_reg <= b1_next;
            b2_reg <= b2_next;
            vld_reg <= b2_reg.vld;
        end
    end
    always_ff @(posedge clk)
    begin
        if (en) data_reg <= {m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8],
                             b2_reg.code};
    end
    assign out_vld = vld_reg;
    assign out_data = data_reg;
endmodule

>>> hdl/ftrm_checker.sv
`timescale 1ns / 1ps
`include "from_to_rotation_matrix_macros.svh"
// ----------------------------------------------------------------------------
// ftrm_checker
// Port-level checks of the rotation matrix block.
// ----------------------------------------------------------------------------
module ftrm_checker (
    input logic clk,
    input logic rst_n,
    input logic empty,
    input logic pop,
    input logic [1:0] case_code,
    input logic cfg_ready
);
    `FTRM_SAME(a_code, !empty, case_code != 2'd3)
    `FTRM_NEXT(a_hold, !empty && !pop, !empty && $stable(case_code))
    `FTRM_SAME(a_cfg, 1'b1, cfg_ready)
endmodule
bind from_to_rotation_matrix ftrm_checker u_chk (.*);

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the from-to rotation matrix block: a bit-exact
// fixed-point predictor feeds a scoreboard of expected matrices, which is
// checked field by field against every result popped from the block.
// ----------------------------------------------------------------------------
module tb;
    import ftrm_pkg::*;

    localparam int DW   = 16;
    localparam int FB   = 14;
    localparam int ONE  = 1 << FB;
    localparam int DMAX = (1 << (DW - 1)) - 1;
    localparam int DMIN = -(1 << (DW - 1));
    localparam int LATENCY = 3 * DW + 8;
    localparam int IDLE_MAX = 18;
    localparam int N_RANDOM = 2000;
    localparam longint CYCLE_LIMIT = 400000;

    typedef logic signed [DW-1:0] elem_t;
    typedef struct packed {
        elem_t [8:0] m;
        logic [1:0]  code;
    } rot_t;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts the rotation for each accepted vector pair and
    // matches popped matrices against the oldest prediction.
    // ------------------------------------------------------------------------
    class rot_scoreboard;
        rot_t   pending[$];
        longint thresh;
        int     errors;

        function new();
            thresh = longint'(THRESH_RESET);
            errors = 0;
        endfunction

        static function longint sat(longint x);
            if (x > DMAX) return DMAX;
            if (x < DMIN) return DMIN;
            return x;
        endfunction

        // product with floor toward minus infinity
        static function longint mulq(longint a, longint b);
            return (a * b) >>> FB;
        endfunction

        static function longint isqrt(longint x);
            longint r, b;
            r = 0;
            b = longint'(1) << 62;
            while (b > x) b = b >> 2;
            while (b != 0) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        static function void cross3(input longint a[3], input longint b[3],
                                    output longint d[3]);
            d[0] = sat(mulq(a[1], b[2]) - mulq(a[2], b[1]));
            d[1] = sat(mulq(a[2], b[0]) - mulq(a[0], b[2]));
            d[2] = sat(mulq(a[0], b[1]) - mulq(a[1], b[0]));
        endfunction

        static function longint dot(input longint a[3], input longint b[3]);
            return sat(mulq(a[0], b[0]) + mulq(a[1], b[1]) + mulq(a[2], b[2]));
        endfunction

        function rot_t rotation(elem_t fv[3], elem_t tv[3]);
            longint f[3], t[3], v[3], l[3], u[3], m[9];
            longint e, len2, inv, s, d, h, hvx, hvy, hvz, hvxy, hvxz, hvyz;
            rot_t r;
            for (int i = 0; i < 3; i++)
            begin
                f[i] = longint'(fv[i]);
                t[i] = longint'(tv[i]);
            end
            cross3(f, t, v);
            e = dot(f, t);
            if (e > ONE - thresh)
            begin
                r.code = CASE_IDENT;
                foreach (m[i]) m[i] = 0;
                m[0] = ONE; m[4] = ONE; m[8] = ONE;
            end else if (e < thresh - ONE)
            begin
                r.code = CASE_ANTI;
                inv = 0;
                l[0] = 0; l[1] = f[2]; l[2] = sat(-f[1]);
                if (dot(l, l) < thresh)
                begin
                    l[0] = sat(-f[2]); l[1] = 0; l[2] = f[0];
                end
                len2 = dot(l, l);
                if (len2 > 0)
                begin
                    s = isqrt(len2 * ONE);
                    if (s != 0) inv = sat((longint'(1) << (2 * FB)) / s);
                end
                for (int i = 0; i < 3; i++) l[i] = sat(mulq(l[i], inv));
                cross3(l, f, u);
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++)
                        m[i*3+j] = sat(-mulq(f[i], f[j]) + mulq(u[i], u[j])
                                       - mulq(l[i], l[j]));
            end else
            begin
                r.code = CASE_GENERAL;
                d = dot(v, v);
                h = 0;
                if (d > 0) h = sat(((ONE - e) * ONE) / d);
                hvx = sat(mulq(h, v[0]));
                hvz = sat(mulq(h, v[2]));
                hvy = sat(mulq(h, v[1]));
                hvxy = sat(mulq(hvx, v[1]));
                hvxz = sat(mulq(hvx, v[2]));
                hvyz = sat(mulq(hvz, v[1]));
                m[0] = sat(e + mulq(hvx, v[0]));
                m[1] = sat(hvxy - v[2]);
                m[2] = sat(hvxz + v[1]);
                m[3] = sat(hvxy + v[2]);
                m[4] = sat(e + mulq(hvy, v[1]));
                m[5] = sat(hvyz - v[0]);
                m[6] = sat(hvxz - v[1]);
                m[7] = sat(hvyz + v[0]);
                m[8] = sat(e + mulq(hvz, v[2]));
            end
            for (int i = 0; i < 9; i++) r.m[i] = elem_t'(m[i]);
            return r;
        endfunction

        function void note_pair(elem_t fv[3], elem_t tv[3]);
            pending.push_back(rotation(fv, tv));
        endfunction

        function void check_matrix(rot_t got);
            rot_t want;
            if (pending.size() == 0)
            begin
                $error("unexpected result transfer");
                errors++;
                return;
            end
            want = pending.pop_front();
            for (int i = 0; i < 9; i++)
                if (got.m[i] !== want.m[i])
                begin
                    $error("m%0d%0d: expected %0d, got %0d", i / 3, i % 3,
                           want.m[i], got.m[i]);
                    errors++;
                end
            if (got.code !== want.code)
            begin
                $error("case_code: expected %0d, got %0d", want.code, got.code);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full, empty, cfg_ready;
    logic pop = 1'b0;
    logic cfg_valid = 1'b0;
    logic [12:0] cfg_data = '0;
    elem_t from_x = '0, from_y = '0, from_z = '0, to_x = '0, to_y = '0, to_z = '0;
    elem_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic [1:0] case_code;

    rot_scoreboard sb = new();
    bit     feeding_done = 1'b0;
    longint cycles = 0;

    always #2 clk = ~clk;

    from_to_rotation_matrix #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) u_top (
        .clk(clk), .rst_n(rst_n),
        .push(push), .full(full),
        .from_x(from_x), .from_y(from_y), .from_z(from_z),
        .to_x(to_x), .to_y(to_y), .to_z(to_z),
        .empty(empty), .pop(pop),
        .m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
        .m20(m20), .m21(m21), .m22(m22), .case_code(case_code),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // Watchdog: generous bound over worst-case idling on both sides.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // Result side: random pop stalls, sampled at the rising edge.
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, IDLE_MAX);
            if ($urandom_range(0, 4) == 0) gap = 0;
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
            sb.check_matrix({{m22, m21, m20, m12, m11, m10, m02, m01, m00}, case_code});
        end
    end

    // One vector-pair transfer; gap cycles of idle first.
    task automatic send_pair(elem_t fv[3], elem_t tv[3], int gap);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push <= 1'b1;
        from_x <= fv[0]; from_y <= fv[1]; from_z <= fv[2];
        to_x <= tv[0]; to_y <= tv[1]; to_z <= tv[2];
        do @(posedge clk); while (full);
        sb.note_pair(fv, tv);
        @(negedge clk);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (LATENCY) @(negedge clk);
    endtask

    // Threshold write, only with the pipeline drained.
    task automatic write_thresh(logic [12:0] val);
        cfg_valid <= 1'b1;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.thresh = longint'(val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic int rand_gap();
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, IDLE_MAX);
    endfunction

    // Rough unit vector: random direction scaled so that length is near ONE.
    function automatic void unit_vec(output elem_t v[3]);
        longint c[3], n2, n;
        do
        begin
            for (int i = 0; i < 3; i++)
                c[i] = longint'($signed($urandom_range(0, 2 * ONE)) - ONE);
            n2 = c[0] * c[0] + c[1] * c[1] + c[2] * c[2];
        end while (n2 < 64 * 64);
        n = rot_scoreboard::isqrt(n2);
        for (int i = 0; i < 3; i++) v[i] = elem_t'((c[i] * ONE) / n);
    endfunction

    task automatic run_random(int count);
        elem_t fv[3], tv[3];
        int kind;
        for (int k = 0; k < count; k++)
        begin
            kind = $urandom_range(0, 9);
            unit_vec(fv);
            if (kind < 4)
                unit_vec(tv);                       // general
            else if (kind < 6)
                for (int i = 0; i < 3; i++)         // near parallel
                    tv[i] = elem_t'(int'(fv[i]) + $signed($urandom_range(0, 16)) - 8);
            else if (kind < 8)
                for (int i = 0; i < 3; i++)         // near anti-parallel
                    tv[i] = elem_t'(-int'(fv[i]) + $signed($urandom_range(0, 16)) - 8);
            else
                for (int i = 0; i < 3; i++)         // raw noise, any bits
                begin
                    fv[i] = elem_t'($urandom());
                    tv[i] = elem_t'($urandom());
                end
            if (kind == 7)                          // anti-parallel with small y,z
            begin
                fv[1] = elem_t'($signed($urandom_range(0, 8)) - 4);
                fv[2] = elem_t'($signed($urandom_range(0, 8)) - 4);
                fv[0] = elem_t'(($urandom_range(0, 1) != 0) ? ONE : -ONE);
                for (int i = 0; i < 3; i++) tv[i] = -fv[i];
            end
            send_pair(fv, tv, rand_gap());
        end
    endtask

    initial
    begin
        elem_t fv[3], tv[3];
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: reset threshold, corner vectors.
        fv = '{ONE, 0, 0}; tv = '{ONE, 0, 0};        send_pair(fv, tv, 0); // identity
        fv = '{ONE, 0, 0}; tv = '{-ONE, 0, 0};       send_pair(fv, tv, 0); // anti, alt left
        fv = '{0, ONE, 0}; tv = '{0, -ONE, 0};       send_pair(fv, tv, 0); // anti, first left
        fv = '{ONE, 0, 0}; tv = '{0, ONE, 0};        send_pair(fv, tv, 1); // general
        fv = '{0, 0, ONE}; tv = '{0, ONE, 0};        send_pair(fv, tv, 0);
        fv = '{0, 0, 0};   tv = '{0, 0, 0};          send_pair(fv, tv, 0); // zero cross
        fv = '{DMAX, DMAX, DMAX}; tv = '{DMAX, DMAX, DMAX}; send_pair(fv, tv, 0);
        fv = '{DMIN, DMIN, DMIN}; tv = '{DMAX, DMAX, DMAX}; send_pair(fv, tv, 0);
        fv = '{DMIN, DMIN, DMIN}; tv = '{DMIN, DMIN, DMIN}; send_pair(fv, tv, 2);
        fv = '{DMAX, DMIN, 0}; tv = '{DMIN, DMAX, DMAX};    send_pair(fv, tv, 0);
        fv = '{ONE, 1, 1}; tv = '{-ONE, -1, -1};     send_pair(fv, tv, 0); // tiny left
        fv = '{-ONE, 2, -3}; tv = '{ONE, -2, 3};     send_pair(fv, tv, 0);
        fv = '{ONE, 0, 0}; tv = '{ONE, 1, 0};        send_pair(fv, tv, 0);
        fv = '{0, -1, 0};  tv = '{0, 0, 1};          send_pair(fv, tv, 0); // h is zero: cross square rounds to zero
        // from zero but to anti-parallel: stays general
        fv = '{0, 0, 0};   tv = '{-ONE, 0, 0};       send_pair(fv, tv, 0);
        drain();                                      // sender waits for all results

        // Zero threshold: exact parallel is no longer identity.
        write_thresh(13'd0);
        fv = '{ONE, 0, 0}; tv = '{ONE, 0, 0};        send_pair(fv, tv, 0);
        fv = '{ONE, 0, 0}; tv = '{-ONE, 0, 0};       send_pair(fv, tv, 0);
        run_random(N_RANDOM / 5);
        drain();

        // Largest threshold: zero vectors still fall into the general branch.
        write_thresh(13'h1FFF);
        fv = '{0, 0, 0};   tv = '{0, 0, 0};          send_pair(fv, tv, 0);
        fv = '{0, 3, 0};   tv = '{0, 0, 0};          send_pair(fv, tv, 0);
        run_random(N_RANDOM / 5);
        drain();

        write_thresh(13'd4096);
        run_random(N_RANDOM / 5);
        drain();

        write_thresh(13'd64);
        run_random(N_RANDOM / 5);
        drain();

        write_thresh(13'd1);
        run_random(N_RANDOM / 5);
        drain();

        if (sb.errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end
endmodule

>>> files.f
+incdir+hdl
hdl/ftrm_pkg.sv
hdl/ftrm_fifo.sv
hdl/ftrm_core.sv
hdl/from_to_rotation_matrix.sv
hdl/ftrm_checker.sv
tb/sv/tb.sv
